[hdl/assert_macros.svh]
// Assertion macros used by the top-level RTL file of the ranging result decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define RRDF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication.
`define RRDF_ASSERT_IMP(lbl, ante, cons, msg) \
  `RRDF_ASSERT(lbl, (ante) |-> (cons), msg)

// Next-cycle implication.
`define RRDF_ASSERT_NXT(lbl, ante, cons, msg) \
  `RRDF_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

[hdl/rrdf_pkg.sv]
// Package for the ranging result decoder: item types, constants and status map.
package rrdf_pkg;

  // Block framing
  localparam int unsigned BLOCK_BYTES       = 17;
  localparam int unsigned STATUS_TABLE_SIZE = 24;
  localparam int unsigned POS_W             = 5;
  localparam logic [POS_W-1:0] POS_LAST     = POS_W'(BLOCK_BYTES - 1);

  // Byte positions of the fields that are kept
  localparam logic [POS_W-1:0] POS_STATUS  = POS_W'(0);
  localparam logic [POS_W-1:0] POS_SPAD    = POS_W'(3);
  localparam logic [POS_W-1:0] POS_AMB_HI  = POS_W'(7);
  localparam logic [POS_W-1:0] POS_AMB_LO  = POS_W'(8);
  localparam logic [POS_W-1:0] POS_DIST_HI = POS_W'(13);
  localparam logic [POS_W-1:0] POS_DIST_LO = POS_W'(14);
  localparam logic [POS_W-1:0] POS_SIG_HI  = POS_W'(15);
  localparam logic [POS_W-1:0] POS_SIG_LO  = POS_W'(16);

  // Range codes
  localparam logic [3:0] CODE_GOOD    = 4'd0;
  localparam logic [3:0] CODE_UNKNOWN = 4'd14;

  // Configuration port
  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;
  localparam logic [1:0] REG_MIN_DIST = 2'd0;
  localparam logic [1:0] REG_MAX_DIST = 2'd1;
  localparam logic [1:0] REG_SHIFT    = 2'd2;
  localparam logic [15:0] MIN_DIST_RST = 16'd40;
  localparam logic [15:0] MAX_DIST_RST = 16'd4000;
  localparam logic [2:0]  SHIFT_RST    = 3'd2;

  typedef logic [23:0] q8_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       block_start;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  range_code;
    logic [7:0]  eff_spads;
    logic [15:0] ambient_rate;
    logic [15:0] signal_rate;
    logic [15:0] distance_mm;
    logic        sample_valid;
    q8_t         filtered_q8;
  } out_item_t;

  // Raw device status to range code; raw codes beyond the table are unknown
  function automatic logic [3:0] map_status(input logic [4:0] raw);
    logic [3:0] code;
    case (raw)
      5'd3:    code = 4'd5;
      5'd4:    code = 4'd2;
      5'd5:    code = 4'd4;
      5'd6:    code = 4'd1;
      5'd7:    code = 4'd7;
      5'd8:    code = 4'd3;
      5'd9:    code = CODE_GOOD;
      5'd12:   code = 4'd9;
      5'd13:   code = 4'd13;
      5'd18:   code = 4'd10;
      5'd19:   code = 4'd6;
      5'd22:   code = 4'd11;
      5'd23:   code = 4'd12;
      default: code = CODE_UNKNOWN;
    endcase
    if (32'(raw) >= STATUS_TABLE_SIZE) begin
      code = CODE_UNKNOWN;
    end
    return code;
  endfunction

endpackage

[hdl/rrdf_ema.sv]
// Exponential average step in Q16.8: seed on first sample, else move by diff >> shift.
module rrdf_ema (
  input  rrdf_pkg::q8_t avg_i,
  input  logic [15:0]   dist_i,
  input  logic [2:0]    shift_i,
  input  logic          seeded_i,
  output rrdf_pkg::q8_t avg_o
);

  rrdf_pkg::q8_t      target;
  logic signed [24:0] diff_s;
  logic signed [24:0] step_s;
  logic [24:0]        sum;

  // Arithmetic shift of the signed difference rounds toward minus infinity
  always_comb begin
    target = {dist_i, 8'h00};
    diff_s = $signed({1'b0, target}) - $signed({1'b0, avg_i});
    step_s = diff_s >>> shift_i;
    sum    = {1'b0, avg_i} + $unsigned(step_s);
    avg_o  = seeded_i ? sum[23:0] : target;
  end

endmodule

[hdl/ranging_result_decode_filter.sv]
// Top level of the ranging result decoder with distance smoothing filter.
//
//  channel | dir | handshake                | payload
//  --------+-----+--------------------------+-----------------------------
//  in      | in  | in_valid_i / in_ready_o  | in_data_i  (rrdf_pkg::in_item_t)
//  out     | out | out_valid_o / out_ready_i| out_data_o (rrdf_pkg::out_item_t)
//  cfg     | in  | psel/penable/pwrite/pready | paddr, pwdata, prdata
//
// One byte is taken per cycle while in_ready_o is high; the last byte of a block loads the result
// register in the same cycle, so a result appears in the cycle after it.
// Bytes are taken while a result waits; only a byte at the last block position stalls
// until the result register is free, through the out_ready_i to in_ready_o path.
// Reset clears position, filter seed and the result valid flag; limits and
// shift return to 40, 4000 and 2.
`include "assert_macros.svh"

module ranging_result_decode_filter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  rrdf_pkg::in_item_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output rrdf_pkg::out_item_t           out_data_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rrdf_pkg::PADDR_W-1:0]  paddr,
  input  logic [rrdf_pkg::PDATA_W-1:0]  pwdata,
  output logic [rrdf_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  // Configuration registers
  logic [15:0] min_dist_q, max_dist_q;
  logic [2:0]  shift_q;
  logic        cfg_we;
  logic [1:0]  reg_idx;

  // Block state
  logic [rrdf_pkg::POS_W-1:0] pos_q, pos_d, pos_eff;
  logic [4:0]  status_q, status_d;
  logic [7:0]  spad_q, spad_d;
  logic [15:0] amb_q, amb_d;
  logic [15:0] dist_q, dist_d;
  logic [7:0]  sig_hi_q, sig_hi_d;
  logic [7:0]  sig_lo_q, sig_lo_d;
  logic        seeded_q, seeded_d;
  rrdf_pkg::q8_t avg_q, avg_d, avg_step;

  // Result register
  logic                out_valid_q;
  rrdf_pkg::out_item_t out_q, out_d;

  logic in_fire, last_byte, emit;
  logic [3:0] code;
  logic       valid;

  // APB register port
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_we  = psel && penable && pwrite;

  always_comb begin
    case (reg_idx)
      rrdf_pkg::REG_MIN_DIST: prdata = {16'h0000, min_dist_q};
      rrdf_pkg::REG_MAX_DIST: prdata = {16'h0000, max_dist_q};
      rrdf_pkg::REG_SHIFT:    prdata = {29'h0, shift_q};
      default:                prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_dist_q <= rrdf_pkg::MIN_DIST_RST;
      max_dist_q <= rrdf_pkg::MAX_DIST_RST;
      shift_q    <= rrdf_pkg::SHIFT_RST;
    end else if (cfg_we) begin
      case (reg_idx)
        rrdf_pkg::REG_MIN_DIST: min_dist_q <= pwdata[15:0];
        rrdf_pkg::REG_MAX_DIST: max_dist_q <= pwdata[15:0];
        rrdf_pkg::REG_SHIFT:    shift_q    <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  // Handshake: only a byte at the last block position waits for the result register
  assign in_ready_o  = out_ready_i || !out_valid_q || (pos_q != rrdf_pkg::POS_LAST);
  assign in_fire     = in_valid_i && in_ready_o;
  assign pos_eff     = in_data_i.block_start ? '0 : pos_q;
  assign last_byte   = (pos_eff == rrdf_pkg::POS_LAST);
  assign emit        = in_fire && last_byte;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Field capture by byte position
  always_comb begin
    status_d = status_q;
    spad_d   = spad_q;
    amb_d    = amb_q;
    dist_d   = dist_q;
    sig_hi_d = sig_hi_q;
    sig_lo_d = sig_lo_q;
    case (pos_eff)
      rrdf_pkg::POS_STATUS:  status_d = in_data_i.data_byte[4:0];
      rrdf_pkg::POS_SPAD:    spad_d   = in_data_i.data_byte;
      rrdf_pkg::POS_AMB_HI:  amb_d    = {in_data_i.data_byte, amb_q[7:0]};
      rrdf_pkg::POS_AMB_LO:  amb_d    = {amb_q[15:8], in_data_i.data_byte};
      rrdf_pkg::POS_DIST_HI: dist_d   = {in_data_i.data_byte, dist_q[7:0]};
      rrdf_pkg::POS_DIST_LO: dist_d   = {dist_q[15:8], in_data_i.data_byte};
      rrdf_pkg::POS_SIG_HI:  sig_hi_d = in_data_i.data_byte;
      rrdf_pkg::POS_SIG_LO:  sig_lo_d = in_data_i.data_byte;
      default: ;
    endcase
    pos_d = last_byte ? '0 : pos_eff + 1'b1;
  end

  // Status, limits and filter for the finished block
  always_comb begin
    code  = rrdf_pkg::map_status(status_d);
    valid = (code == rrdf_pkg::CODE_GOOD) && (dist_d >= min_dist_q) && (dist_d <= max_dist_q);
    avg_d    = valid ? avg_step : avg_q;
    seeded_d = seeded_q || valid;
  end

  rrdf_ema u_ema (
    .avg_i    (avg_q),
    .dist_i   (dist_d),
    .shift_i  (shift_q),
    .seeded_i (seeded_q),
    .avg_o    (avg_step)
  );

  always_comb begin
    out_d.range_code   = code;
    out_d.eff_spads    = spad_d;
    out_d.ambient_rate = {amb_d[12:0], 3'b000};
    out_d.signal_rate  = {sig_hi_d[4:0], sig_lo_d, 3'b000};
    out_d.distance_mm  = dist_d;
    out_d.sample_valid = valid;
    out_d.filtered_q8  = avg_d;
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      status_q <= '0;
      spad_q   <= '0;
      amb_q    <= '0;
      dist_q   <= '0;
      sig_hi_q <= '0;
      sig_lo_q <= '0;
      seeded_q <= 1'b0;
      avg_q    <= '0;
    end else if (in_fire) begin
      pos_q    <= pos_d;
      status_q <= status_d;
      spad_q   <= spad_d;
      amb_q    <= amb_d;
      dist_q   <= dist_d;
      sig_hi_q <= sig_hi_d;
      sig_lo_q <= sig_lo_d;
      if (last_byte) begin
        seeded_q <= seeded_d;
        avg_q    <= avg_d;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= out_d;
    end
  end

  // Checks
  `RRDF_ASSERT(a_pos_range, pos_q <= rrdf_pkg::POS_LAST, "byte position past end of block")
  `RRDF_ASSERT_NXT(a_emit_valid, emit, out_valid_q, "finished block gave no result")
  `RRDF_ASSERT_IMP(a_unseeded_zero, !seeded_q, avg_q == '0, "average moved before first sample")
  `RRDF_ASSERT_IMP(a_valid_good, out_valid_q && out_q.sample_valid, out_q.range_code == rrdf_pkg::CODE_GOOD, "valid sample with bad status")

endmodule
